### src/target_block_tracker_macros.svh
// Assertion macros for the target block tracker.
`ifndef TARGET_BLOCK_TRACKER_MACROS_SVH
`define TARGET_BLOCK_TRACKER_MACROS_SVH

// Same-cycle implication, clocked on aclk and disabled during reset.
`define TBT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and disabled during reset.
`define TBT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tbt_pkg.sv
// Shared types and constants for the target block tracker.
package tbt_pkg;

    localparam int SIG_W     = 16;   // block signature
    localparam int POS_W     = 9;    // pixel position / width
    localparam int LIM_W     = 8;    // loss counter and limit
    localparam int PIX_W     = 11;   // held point and angle
    localparam int CFG_IDX_W = 1;
    localparam int DIV_W     = 13;   // image width divisor, up to 8191
    localparam int MAG_W     = 18;   // |point * fov| stays below 2**MAG_W
    localparam int PROD_W    = MAG_W + 1;
    localparam int NLANES    = 3;    // centre, left, right

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SIG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT = 1'd1;

    localparam logic [SIG_W-1:0] TARGET_SIG_RST = 16'd1;
    localparam logic [LIM_W-1:0] LOST_LIMIT_RST = 8'd10;

    localparam logic KIND_BLOCK = 1'b0;
    localparam logic KIND_EOF   = 1'b1;

    localparam logic [1:0] STATUS_SEEN = 2'd0;
    localparam logic [1:0] STATUS_HOLD = 2'd1;
    localparam logic [1:0] STATUS_LOST = 2'd2;

    // One frame result in pixel space, handed from front to back.
    typedef struct packed {
        logic signed [PIX_W-1:0] centre;
        logic signed [PIX_W-1:0] left;
        logic signed [PIX_W-1:0] right;
        logic [1:0]              status;
    } tbt_rec_t;

endpackage

### src/target_block_tracker.sv
// Top level of the target block tracker: front end, queue, angle pipeline.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    kind, signature, centre_x, block_width
//   m_        out        m_valid/m_ready    centre/left/right angle, status
//   cfg_      in         cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// One input transaction per cycle. Block transactions update the frame's best
// match in the front end in the cycle they are accepted; an end-of-frame
// transaction makes one result, which passes the queue, the pipeline stages and
// the output register. The pipeline runs three lanes (centre, left, right) through
// multiply, reciprocal estimate, back-multiply and one correction step. s_ready
// drops only while the QUEUE_DEPTH entry queue is full; m_ready low with a result
// held freezes the whole angle pipeline. Synchronous active-low reset, no clearing pass.
`include "target_block_tracker_macros.svh"

module target_block_tracker #(
    parameter int FOV_DEGREES  = 75,
    parameter int IMAGE_WIDTH  = 320,
    parameter int IMAGE_CENTRE = 160,
    parameter int LOST_MARK    = 1000,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tbt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tbt_pkg::SIG_W-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [tbt_pkg::SIG_W-1:0]           s_signature,
    input  logic [tbt_pkg::POS_W-1:0]           s_centre_x,
    input  logic [tbt_pkg::POS_W-1:0]           s_block_width,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tbt_pkg::PIX_W-1:0]    m_centre_angle,
    output logic signed [tbt_pkg::PIX_W-1:0]    m_left_angle,
    output logic signed [tbt_pkg::PIX_W-1:0]    m_right_angle,
    output logic [1:0]                          m_status
);
    import tbt_pkg::*;

    // front -> queue
    logic     push;
    tbt_rec_t push_rec;
    logic     q_full;
    // queue -> angle pipeline
    logic     q_pop;
    logic     q_empty;
    tbt_rec_t q_rec;

    // classification and frame-end decisions, all in pixel space
    tbt_front #(
        .IMAGE_CENTRE (IMAGE_CENTRE),
        .LOST_MARK    (LOST_MARK)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_signature   (s_signature),
        .s_centre_x    (s_centre_x),
        .s_block_width (s_block_width),
        .push          (push),
        .push_rec      (push_rec),
        .q_full        (q_full)
    );

    // decouples frame-end decisions from output back-pressure
    tbt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .rd_rec   (q_rec)
    );

    // pixel-to-angle conversion; lost marks pass through untouched
    tbt_angle #(
        .FOV_DEGREES (FOV_DEGREES),
        .IMAGE_WIDTH (IMAGE_WIDTH),
        .LOST_MARK   (LOST_MARK)
    ) u_angle (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_rec          (q_rec),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_centre_angle (m_centre_angle),
        .m_left_angle   (m_left_angle),
        .m_right_angle  (m_right_angle),
        .m_status       (m_status)
    );

    // queue never written while full nor read while empty
    `TBT_ASSERT_IMP(a_no_overflow, push, !q_full, "frame result pushed into full queue")
    `TBT_ASSERT_IMP(a_no_underflow, q_pop, !q_empty, "angle pipeline popped empty queue")
    // a lone push must leave something for the back end
    `TBT_ASSERT_NXT(a_push_lands, push && !q_pop, !q_empty, "pushed frame result vanished")
    // on loss all three points carry the same mark
    `TBT_ASSERT_IMP(a_lost_flat, m_valid && (m_status == STATUS_LOST), (m_centre_angle == m_left_angle) && (m_left_angle == m_right_angle), "lost result with unequal points")

endmodule

### src/tbt_front.sv
// Front end: config registers, per-frame best block search and frame-end decision.
module tbt_front #(
    parameter int IMAGE_CENTRE = 160,
    parameter int LOST_MARK    = 1000
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbt_pkg::SIG_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [tbt_pkg::SIG_W-1:0]      s_signature,
    input  logic [tbt_pkg::POS_W-1:0]      s_centre_x,
    input  logic [tbt_pkg::POS_W-1:0]      s_block_width,
    output logic                           push,
    output tbt_pkg::tbt_rec_t              push_rec,
    input  logic                           q_full
);
    import tbt_pkg::*;

    localparam logic signed [PIX_W-1:0] MARK_POS = PIX_W'(LOST_MARK);
    localparam logic signed [PIX_W-1:0] MARK_NEG = -MARK_POS;
    localparam logic signed [DIV_W:0]   CENTRE_S = (DIV_W+1)'(IMAGE_CENTRE);

    logic [SIG_W-1:0]        target_reg;
    logic [LIM_W-1:0]        limit_reg;
    logic [POS_W-1:0]        best_width_reg;
    logic [POS_W-1:0]        best_centre_reg;
    logic                    match_seen_reg;
    logic [LIM_W-1:0]        lost_count_reg;
    logic [LIM_W-1:0]        lost_count_next;
    logic signed [PIX_W-1:0] held_centre_reg;
    logic signed [PIX_W-1:0] held_left_reg;
    logic signed [PIX_W-1:0] held_right_reg;

    logic                    accept;
    logic                    is_match;
    logic [POS_W-2:0]        half_width;
    logic signed [PIX_W-1:0] pt_centre;
    logic signed [PIX_W-1:0] pt_left;
    logic signed [PIX_W-1:0] pt_right;
    logic [LIM_W:0]          count_inc;
    logic                    over_limit;
    logic                    right_of_centre;
    logic signed [PIX_W-1:0] mark;
    tbt_rec_t                rec_next;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign is_match = (s_signature == target_reg)
                      && (!match_seen_reg || (s_block_width > best_width_reg));

    assign half_width = best_width_reg[POS_W-1:1];
    assign pt_centre  = PIX_W'(best_centre_reg);
    assign pt_left    = PIX_W'(best_centre_reg) - PIX_W'(half_width);
    assign pt_right   = PIX_W'(best_centre_reg) + PIX_W'(half_width);

    assign count_inc       = {1'b0, lost_count_reg} + (LIM_W+1)'(1);
    assign over_limit      = count_inc > {1'b0, limit_reg};
    assign right_of_centre = (DIV_W+1)'(held_centre_reg) > CENTRE_S;
    assign mark            = right_of_centre ? MARK_POS : MARK_NEG;

    always_comb begin
        lost_count_next = count_inc[LIM_W-1:0];
        if (match_seen_reg) begin
            rec_next        = '{pt_centre, pt_left, pt_right, STATUS_SEEN};
            lost_count_next = '0;
        end else if (over_limit) begin
            rec_next        = '{mark, mark, mark, STATUS_LOST};
            lost_count_next = '0;
        end else begin
            rec_next = '{held_centre_reg, held_left_reg, held_right_reg, STATUS_HOLD};
        end
    end

    assign push     = accept && (s_kind == KIND_EOF);
    assign push_rec = rec_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg      <= TARGET_SIG_RST;
            limit_reg       <= LOST_LIMIT_RST;
            best_width_reg  <= '0;
            best_centre_reg <= '0;
            match_seen_reg  <= 1'b0;
            lost_count_reg  <= '0;
            held_centre_reg <= '0;
            held_left_reg   <= '0;
            held_right_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TARGET_SIG: target_reg <= cfg_wdata;
                    REG_LOST_LIMIT: limit_reg  <= cfg_wdata[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (s_kind == KIND_BLOCK) begin
                    if (is_match) begin
                        best_width_reg  <= s_block_width;
                        best_centre_reg <= s_centre_x;
                        match_seen_reg  <= 1'b1;
                    end
                end else begin
                    held_centre_reg <= rec_next.centre;
                    held_left_reg   <= rec_next.left;
                    held_right_reg  <= rec_next.right;
                    lost_count_reg  <= lost_count_next;
                    best_width_reg  <= '0;
                    best_centre_reg <= '0;
                    match_seen_reg  <= 1'b0;
                end
            end
        end
    end

endmodule

### src/tbt_queue.sv
// Small register FIFO between the front end and the angle pipeline.
module tbt_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tbt_pkg::tbt_rec_t push_rec,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output tbt_pkg::tbt_rec_t rd_rec
);
    import tbt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tbt_rec_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full   = count_reg == CNT_W'(DEPTH);
    assign empty  = count_reg == '0;
    assign rd_rec = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### src/tbt_angle.sv
// Back end: pixel-to-angle pipeline, three lanes, with output register.
module tbt_angle #(
    parameter int FOV_DEGREES = 75,
    parameter int IMAGE_WIDTH = 320,
    parameter int LOST_MARK   = 1000
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    input  tbt_pkg::tbt_rec_t                   q_rec,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tbt_pkg::PIX_W-1:0]    m_centre_angle,
    output logic signed [tbt_pkg::PIX_W-1:0]    m_left_angle,
    output logic signed [tbt_pkg::PIX_W-1:0]    m_right_angle,
    output logic [1:0]                          m_status
);
    import tbt_pkg::*;

    localparam int ANG_W = PROD_W + 1;

    localparam logic signed [PROD_W-1:0] FOV_S   = PROD_W'(FOV_DEGREES);
    localparam logic [MAG_W-1:0]         RECIP   = MAG_W'((1 << MAG_W) / IMAGE_WIDTH);
    localparam logic [DIV_W-1:0]         DIVISOR = DIV_W'(IMAGE_WIDTH);
    localparam logic signed [ANG_W-1:0]  HALF    = ANG_W'(FOV_DEGREES / 2);
    localparam logic signed [PIX_W-1:0]  MARK    = PIX_W'(LOST_MARK);
    localparam logic signed [ANG_W-1:0]  SAT_HI  = ANG_W'((1 << (PIX_W - 1)) - 1);
    localparam logic signed [ANG_W-1:0]  SAT_LO  = -ANG_W'(1 << (PIX_W - 1));

    logic adv;

    // stage 1: point * fov
    logic                    s1_valid_reg;
    logic [1:0]              s1_status_reg;
    logic signed [PIX_W-1:0] s1_pt_reg   [NLANES];
    logic                    s1_pass_reg [NLANES];
    logic signed [PROD_W-1:0] s1_prod_reg [NLANES];

    // stage 2: magnitude and reciprocal estimate
    logic                    s2_valid_reg;
    logic [1:0]              s2_status_reg;
    logic signed [PIX_W-1:0] s2_pt_reg   [NLANES];
    logic                    s2_pass_reg [NLANES];
    logic                    s2_neg_reg  [NLANES];
    logic [MAG_W-1:0]        s2_mag_reg  [NLANES];
    logic [MAG_W-1:0]        s2_qe_reg   [NLANES];

    // stage 3: estimate * divisor
    logic                    s3_valid_reg;
    logic [1:0]              s3_status_reg;
    logic signed [PIX_W-1:0] s3_pt_reg   [NLANES];
    logic                    s3_pass_reg [NLANES];
    logic                    s3_neg_reg  [NLANES];
    logic [MAG_W-1:0]        s3_mag_reg  [NLANES];
    logic [MAG_W-1:0]        s3_qe_reg   [NLANES];
    logic [MAG_W-1:0]        s3_qd_reg   [NLANES];

    logic                    m_valid_reg;
    logic [1:0]              m_status_reg;
    logic signed [PIX_W-1:0] m_angle_reg [NLANES];

    logic signed [PIX_W-1:0]  in_pt    [NLANES];
    logic                     in_pass  [NLANES];
    logic signed [PROD_W-1:0] in_prod  [NLANES];
    logic                     s1_neg   [NLANES];
    logic [MAG_W-1:0]         s1_mag   [NLANES];
    logic [2*MAG_W-1:0]       s1_full  [NLANES];
    logic [MAG_W+DIV_W-1:0]   s2_qd    [NLANES];
    logic [MAG_W-1:0]         s3_rem   [NLANES];
    logic [MAG_W-1:0]         s3_q     [NLANES];
    logic signed [ANG_W-1:0]  s3_qs    [NLANES];
    logic signed [ANG_W-1:0]  s3_ang   [NLANES];
    logic signed [PIX_W-1:0]  s3_out   [NLANES];

    // whole pipe stalls only when the output holds an untaken result
    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && !q_empty;

    assign in_pt[0] = q_rec.centre;
    assign in_pt[1] = q_rec.left;
    assign in_pt[2] = q_rec.right;

    always_comb begin
        for (int i = 0; i < NLANES; i++) begin
            in_pass[i] = !((in_pt[i] < MARK) && (in_pt[i] > -MARK));
            in_prod[i] = PROD_W'(in_pt[i]) * FOV_S;

            s1_neg[i]  = s1_prod_reg[i] < 0;
            s1_mag[i]  = s1_neg[i] ? MAG_W'(-s1_prod_reg[i]) : MAG_W'(s1_prod_reg[i]);
            s1_full[i] = (2*MAG_W)'(s1_mag[i]) * (2*MAG_W)'(RECIP);

            s2_qd[i] = (MAG_W+DIV_W)'(s2_qe_reg[i]) * (MAG_W+DIV_W)'(DIVISOR);

            // estimate is at most one short of the true quotient
            s3_rem[i] = s3_mag_reg[i] - s3_qd_reg[i];
            s3_q[i]   = s3_qe_reg[i] + MAG_W'(s3_rem[i] >= MAG_W'(DIVISOR));
            s3_qs[i]  = $signed(ANG_W'(s3_q[i]));
            s3_ang[i] = (s3_neg_reg[i] ? -s3_qs[i] : s3_qs[i]) - HALF;
            if (s3_pass_reg[i]) begin
                s3_out[i] = s3_pt_reg[i];
            end else if (s3_ang[i] > SAT_HI) begin
                s3_out[i] = SAT_HI[PIX_W-1:0];
            end else if (s3_ang[i] < SAT_LO) begin
                s3_out[i] = SAT_LO[PIX_W-1:0];
            end else begin
                s3_out[i] = s3_ang[i][PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= !q_empty;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_status_reg <= q_rec.status;
            s2_status_reg <= s1_status_reg;
            s3_status_reg <= s2_status_reg;
            m_status_reg  <= s3_status_reg;
            for (int i = 0; i < NLANES; i++) begin
                s1_pt_reg[i]   <= in_pt[i];
                s1_pass_reg[i] <= in_pass[i];
                s1_prod_reg[i] <= in_prod[i];

                s2_pt_reg[i]   <= s1_pt_reg[i];
                s2_pass_reg[i] <= s1_pass_reg[i];
                s2_neg_reg[i]  <= s1_neg[i];
                s2_mag_reg[i]  <= s1_mag[i];
                s2_qe_reg[i]   <= s1_full[i][2*MAG_W-1:MAG_W];

                s3_pt_reg[i]   <= s2_pt_reg[i];
                s3_pass_reg[i] <= s2_pass_reg[i];
                s3_neg_reg[i]  <= s2_neg_reg[i];
                s3_mag_reg[i]  <= s2_mag_reg[i];
                s3_qe_reg[i]   <= s2_qe_reg[i];
                s3_qd_reg[i]   <= s2_qd[i][MAG_W-1:0];

                m_angle_reg[i] <= s3_out[i];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_centre_angle = m_angle_reg[0];
    assign m_left_angle   = m_angle_reg[1];
    assign m_right_angle  = m_angle_reg[2];

endmodule
